[rtl/bibcrc_pkg.sv]
package bibcrc_pkg;

  localparam int unsigned QuadletW  = 32;
  localparam int unsigned CrcW      = 16;
  localparam int unsigned PosW      = 3;
  localparam int unsigned OutDataW  = 144;

  localparam logic [PosW-1:0] BibQuadlets = 3'd5;
  localparam logic [7:0]      MaxCovered  = 8'd4;
  localparam logic [CrcW-1:0] PolyReset   = 16'h1021;

  localparam logic [PosW-1:0] PosHeader  = 3'd0;
  localparam logic [PosW-1:0] PosCap     = 3'd2;
  localparam logic [PosW-1:0] PosIdHigh  = 3'd3;
  localparam logic [PosW-1:0] PosIdLow   = 3'd4;

  localparam logic [2:0] StatusOk           = 3'd0;
  localparam logic [2:0] StatusMismatch     = 3'd1;
  localparam logic [2:0] StatusNotPresent   = 3'd2;
  localparam logic [2:0] StatusNotCheckable = 3'd3;
  localparam logic [2:0] StatusTooShort     = 3'd4;

  // first member at the top bits, check_status lands in the lowest bits
  typedef struct packed {
    logic [2:0]  pad;
    logic [63:0] unique_id;
    logic [2:0]  link_speed;
    logic [3:0]  generation_count;
    logic [1:0]  max_rom_code;
    logic [3:0]  max_record;
    logic [7:0]  clock_accuracy;
    logic [4:0]  capability_flags;
    logic [15:0] computed_crc;
    logic [15:0] stored_crc;
    logic [7:0]  covered_length;
    logic [7:0]  info_length;
    logic [2:0]  check_status;
  } result_t;

  // xor in one halfword, then 16 shifts with polynomial feedback
  function automatic logic [CrcW-1:0] crc_half(
    input logic [CrcW-1:0] crc,
    input logic [CrcW-1:0] half,
    input logic [CrcW-1:0] poly
  );
    logic [CrcW-1:0] c;
    c = crc ^ half;
    for (int i = 0; i < 16; i++) begin
      if (c[CrcW-1]) begin
        c = {c[CrcW-2:0], 1'b0} ^ poly;
      end else begin
        c = {c[CrcW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[rtl/bus_info_block_crc_check_unit.sv]
// Checks an IEEE 1212 bus-info block: quadlets come in one beat each on the
// in_ stream with tlast on the final one, and one result beat comes out per
// block, in the cycle after its last quadlet, carrying the CRC-16 status and
// the unpacked header, capability and unique-id fields. One quadlet is taken
// every cycle; the CRC update of both halfwords (32 feedback shifts) is
// combinational. The input stalls only while a finished result sits in the
// output register and out_tready is low. The user must write the polynomial
// via cfg_wr_en/cfg_wr_data only while no block is in progress (unenforced).
module bus_info_block_crc_check_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // quadlet
  input  logic         in_tlast,   // last_word
  output logic         out_tvalid,
  input  logic         out_tready,
  // check_status, info_length, covered_length, stored_crc, computed_crc,
  // capability_flags, clock_accuracy, max_record, max_rom_code,
  // generation_count, link_speed, unique_id, zero pad
  output logic [143:0] out_tdata
);

  logic [15:0] poly_r;
  logic [2:0]  pos_r, pos_nxt;
  logic [31:0] header_r, header_nxt;
  logic [31:0] cap_r, cap_nxt;
  logic [31:0] idh_r, idh_nxt;
  logic [31:0] idl_r, idl_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  bibcrc_pkg::result_t res_r, res_nxt;

  logic        in_beat;
  logic        crc_en;
  logic [15:0] crc_upd;
  logic [7:0]  covered;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_beat    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

  assign crc_upd = bibcrc_pkg::crc_half(
                     bibcrc_pkg::crc_half(crc_r, in_tdata[31:16], poly_r),
                     in_tdata[15:0], poly_r);
  assign crc_en  = (pos_r != bibcrc_pkg::PosHeader) &&
                   ({5'd0, pos_r} <= header_r[23:16]);

  always_comb begin
    pos_nxt    = pos_r;
    header_nxt = header_r;
    cap_nxt    = cap_r;
    idh_nxt    = idh_r;
    idl_nxt    = idl_r;
    crc_nxt    = crc_r;
    if (pos_r < bibcrc_pkg::BibQuadlets) begin
      if (pos_r == bibcrc_pkg::PosHeader) header_nxt = in_tdata;
      if (pos_r == bibcrc_pkg::PosCap)    cap_nxt    = in_tdata;
      if (pos_r == bibcrc_pkg::PosIdHigh) idh_nxt    = in_tdata;
      if (pos_r == bibcrc_pkg::PosIdLow)  idl_nxt    = in_tdata;
      if (crc_en) crc_nxt = crc_upd;
      pos_nxt = pos_r + 3'd1;
    end
  end

  assign covered = header_nxt[23:16];

  always_comb begin
    res_nxt = '0;
    if (pos_nxt < bibcrc_pkg::BibQuadlets) begin
      res_nxt.check_status = bibcrc_pkg::StatusTooShort;
    end else begin
      if (covered == 8'd0) begin
        res_nxt.check_status = bibcrc_pkg::StatusNotPresent;
      end else if (covered > bibcrc_pkg::MaxCovered) begin
        res_nxt.check_status = bibcrc_pkg::StatusNotCheckable;
      end else begin
        res_nxt.computed_crc = crc_nxt;
        res_nxt.check_status = (crc_nxt == header_nxt[15:0]) ?
                               bibcrc_pkg::StatusOk : bibcrc_pkg::StatusMismatch;
      end
      res_nxt.info_length      = header_nxt[31:24];
      res_nxt.covered_length   = covered;
      res_nxt.stored_crc       = header_nxt[15:0];
      res_nxt.capability_flags = cap_nxt[31:27];
      res_nxt.clock_accuracy   = cap_nxt[23:16];
      res_nxt.max_record       = cap_nxt[15:12];
      res_nxt.max_rom_code     = cap_nxt[9:8];
      res_nxt.generation_count = cap_nxt[7:4];
      res_nxt.link_speed       = cap_nxt[2:0];
      res_nxt.unique_id        = {idh_nxt, idl_nxt};
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (in_beat && in_tlast) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r      <= bibcrc_pkg::PolyReset;
      pos_r       <= '0;
      header_r    <= '0;
      cap_r       <= '0;
      idh_r       <= '0;
      idl_r       <= '0;
      crc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) poly_r <= cfg_wr_data;
      out_valid_r <= out_valid_nxt;
      if (in_beat) begin
        header_r <= header_nxt;
        cap_r    <= cap_nxt;
        idh_r    <= idh_nxt;
        idl_r    <= idl_nxt;
        if (in_tlast) begin
          pos_r <= '0;
          crc_r <= '0;
        end else begin
          pos_r <= pos_nxt;
          crc_r <= crc_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat && in_tlast) res_r <= res_nxt;
  end

endmodule
